// File: rtl/heat_pkg.sv
package heat_pkg;

  // cell storage width, signed Q16.16
  localparam int DATA_WIDTH = 32;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // request field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W   = 7;
  localparam int ITER_W  = 16;
  localparam int COEF_W  = 16;

  // commands
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COEF = 2'd3;

  // config reset values
  localparam logic [DIM_W-1:0]  ROW_COUNT_RST = 7'd64;
  localparam logic [DIM_W-1:0]  COL_COUNT_RST = 7'd64;
  localparam logic [ITER_W-1:0] ITER_COUNT_RST = 16'd1;
  localparam logic [COEF_W-1:0] COEF_RST = 16'd16384;

endpackage

// File: rtl/heat_stencil_solver_unit.sv
// Write request: accepted from idle, block ready again next cycle. Read request: the grid read
// is registered, then the result is loaded into the output register and held there until taken.
// Run request: each sweep copies rows into the line buffer, then updates every interior cell in
// a 7-step sequence on the shared accumulate/multiply datapath; one request at a time.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops any pending result and
// restores config registers to 64/64/1/16384; grid and line buffers are undefined until written.
module heat_stencil_solver_unit #(
  parameter int MAX_ROWS = heat_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = heat_pkg::MAX_COLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [heat_pkg::CMD_W-1:0]           in_command,
  input  logic [heat_pkg::IDX_W-1:0]           in_row,
  input  logic [heat_pkg::IDX_W-1:0]           in_col,
  input  logic signed [heat_pkg::DATA_WIDTH-1:0] in_cell_in,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [heat_pkg::DATA_WIDTH-1:0] out_cell_out,
  output logic                                 out_kind,
  // config write port
  input  logic                                 cfg_we,
  input  logic [heat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [heat_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int DW    = heat_pkg::DATA_WIDTH;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = $clog2(MAX_ROWS);     // row index
  localparam int CIW   = $clog2(MAX_COLS);     // column index
  localparam int RCW   = $clog2(MAX_ROWS + 1); // row count
  localparam int CCW   = $clog2(MAX_COLS + 1); // column count
  localparam int LAW   = CIW + 1;              // line buffer: {bank, col}
  localparam int ACCW  = DW + 3;               // up+down+left+right-4c
  localparam int PRODW = ACCW + heat_pkg::COEF_W + 1;
  localparam int QW    = PRODW - 16;
  localparam int SUMW  = QW + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDATA = 3'd1; // read data registered, waiting for output slot
  localparam logic [2:0] S_FILL  = 3'd2; // issue grid read for line-buffer copy
  localparam logic [2:0] S_FILLW = 3'd3; // write line buffer
  localparam logic [2:0] S_CELL  = 3'd4; // 7-step stencil on one interior cell
  localparam logic [2:0] S_DONE  = 3'd5; // post run-finished result

  // memories
  logic [DW-1:0] grid_mem [DEPTH];
  logic [DW-1:0] line_mem [2*MAX_COLS];

  logic          g_we, g_re;
  logic [AW-1:0] g_wa, g_ra;
  logic [DW-1:0] g_wd, g_q_r;
  logic           lb_we;
  logic [LAW-1:0] lb_wa, lb_ra;
  logic [DW-1:0]  lb_wd, lb_q_r;

  // grid read data holds until the next read, so a read result survives an output stall
  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_wa] <= g_wd;
    end
    if (g_re) begin
      g_q_r <= grid_mem[g_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      line_mem[lb_wa] <= lb_wd;
    end
    lb_q_r <= line_mem[lb_ra];
  end

  // config registers
  logic [heat_pkg::DIM_W-1:0]  row_count_r, col_count_r;
  logic [heat_pkg::ITER_W-1:0] iter_count_r;
  logic [heat_pkg::COEF_W-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r  <= heat_pkg::ROW_COUNT_RST;
      col_count_r  <= heat_pkg::COL_COUNT_RST;
      iter_count_r <= heat_pkg::ITER_COUNT_RST;
      coef_r       <= heat_pkg::COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        heat_pkg::REG_ROW_COUNT:     row_count_r  <= cfg_wdata[heat_pkg::DIM_W-1:0];
        heat_pkg::REG_COL_COUNT:     col_count_r  <= cfg_wdata[heat_pkg::DIM_W-1:0];
        heat_pkg::REG_ITER_COUNT:    iter_count_r <= cfg_wdata[heat_pkg::ITER_W-1:0];
        heat_pkg::REG_NEIGHBOR_COEF: coef_r       <= cfg_wdata[heat_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // row-major grid address
  function automatic logic [AW-1:0] gaddr(input logic [RIW-1:0] r, input logic [CIW-1:0] c);
    gaddr = AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  // control and datapath registers
  logic [2:0]                  state_r, state_nxt;
  logic [RCW-1:0]              ri_r, ri_nxt;       // current row of the sweep
  logic [CIW-1:0]              cj_r, cj_nxt;       // current column
  logic                        bank_r, bank_nxt;   // line-buffer bank holding current row
  logic [2:0]                  k_r, k_nxt;         // cell step
  logic [heat_pkg::ITER_W-1:0] it_r, it_nxt;
  logic [RCW-1:0]              rows_r, rows_nxt;
  logic [CCW-1:0]              cols_r, cols_nxt;
  logic                        inside_r, inside_nxt;
  logic signed [ACCW-1:0]      acc_r, acc_nxt;
  logic signed [PRODW-1:0]     prod_r, prod_nxt;
  logic [DW-1:0]               c_r, c_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [DW-1:0]               out_cell_r, out_cell_nxt;
  logic                        out_kind_r, out_kind_nxt;

  // helpers
  logic [RCW-1:0]         rows_eff, ri_dn;
  logic [CCW-1:0]         cols_eff;
  logic                   in_inside, out_free;
  logic signed [PRODW-1:0] rnd;
  logic signed [QW-1:0]    q;
  logic signed [SUMW-1:0]  sum;
  logic [DW-1:0]           sat;

  always_comb begin
    rows_eff = (32'(row_count_r) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(row_count_r);
    cols_eff = (32'(col_count_r) > 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(col_count_r);
    in_inside = (32'(in_row) < 32'(MAX_ROWS)) && (32'(in_col) < 32'(MAX_COLS));
    out_free  = !out_valid_r || !out_stall;
    ri_dn     = ri_r + RCW'(1);

    // c + round(d*k / 65536), ties toward +inf, then saturate
    rnd = prod_r + PRODW'(32768);
    q   = rnd[PRODW-1:16];
    sum = {{(SUMW-DW){c_r[DW-1]}}, c_r} + {q[QW-1], q};
    if (sum[SUMW-1:DW-1] == {(SUMW-DW+1){1'b0}} ||
        sum[SUMW-1:DW-1] == {(SUMW-DW+1){1'b1}}) begin
      sat = sum[DW-1:0];
    end else if (sum[SUMW-1]) begin
      sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ri_nxt     = ri_r;
    cj_nxt     = cj_r;
    bank_nxt   = bank_r;
    k_nxt      = k_r;
    it_nxt     = it_r;
    rows_nxt   = rows_r;
    cols_nxt   = cols_r;
    inside_nxt = inside_r;
    acc_nxt    = acc_r;
    prod_nxt   = prod_r;
    c_nxt      = c_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cell_nxt  = out_cell_r;
    out_kind_nxt  = out_kind_r;
    g_we  = 1'b0;
    g_re  = 1'b0;
    g_wa  = '0;
    g_wd  = in_cell_in;
    g_ra  = '0;
    lb_we = 1'b0;
    lb_wa = {bank_r, cj_r};
    lb_wd = g_q_r;
    lb_ra = {bank_r, cj_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            heat_pkg::CMD_WRITE: begin
              g_we = in_inside;
              g_wa = gaddr(RIW'(in_row), CIW'(in_col));
            end
            heat_pkg::CMD_READ: begin
              g_re       = 1'b1;
              g_ra       = gaddr(RIW'(in_row), CIW'(in_col));
              inside_nxt = in_inside;
              state_nxt  = S_RDATA;
            end
            heat_pkg::CMD_RUN: begin
              rows_nxt = rows_eff;
              cols_nxt = cols_eff;
              it_nxt   = '0;
              ri_nxt   = '0;
              cj_nxt   = '0;
              bank_nxt = 1'b0;
              // no interior or no sweeps: answer at once
              if (rows_eff < RCW'(3) || cols_eff < CCW'(3) || iter_count_r == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_FILL;
              end
            end
            default: ; // unused command: dropped
          endcase
        end
      end

      S_RDATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = inside_r ? g_q_r : '0;
          out_kind_nxt  = heat_pkg::KIND_READ;
          state_nxt     = S_IDLE;
        end
      end

      S_FILL: begin
        g_re      = 1'b1;
        g_ra      = gaddr(ri_r[RIW-1:0], cj_r);
        state_nxt = S_FILLW;
      end

      S_FILLW: begin
        lb_we = 1'b1;
        if (CCW'(cj_r) == cols_r - CCW'(1)) begin
          if (ri_r == '0) begin
            // row 0 parked as previous row, now copy row 1
            bank_nxt  = ~bank_r;
            ri_nxt    = RCW'(1);
            cj_nxt    = '0;
            state_nxt = S_FILL;
          end else begin
            cj_nxt    = CIW'(1);
            k_nxt     = '0;
            state_nxt = S_CELL;
          end
        end else begin
          cj_nxt    = cj_r + CIW'(1);
          state_nxt = S_FILL;
        end
      end

      S_CELL: begin
        k_nxt = k_r + 3'd1;
        case (k_r)
          3'd0: begin
            lb_ra = {bank_r, cj_r};                // center
            g_re  = 1'b1;
            g_ra  = gaddr(ri_dn[RIW-1:0], cj_r);   // below, still old
          end
          3'd1: begin
            lb_ra   = {bank_r, cj_r - CIW'(1)};    // left
            c_nxt   = lb_q_r;
            acc_nxt = $signed({{3{g_q_r[DW-1]}}, g_q_r}) -
                      $signed({lb_q_r[DW-1], lb_q_r, 2'b00});
          end
          3'd2: begin
            lb_ra   = {bank_r, cj_r + CIW'(1)};    // right
            acc_nxt = acc_r + $signed({{3{lb_q_r[DW-1]}}, lb_q_r});
          end
          3'd3: begin
            lb_ra   = {~bank_r, cj_r};             // above, old copy
            acc_nxt = acc_r + $signed({{3{lb_q_r[DW-1]}}, lb_q_r});
          end
          3'd4: begin
            acc_nxt = acc_r + $signed({{3{lb_q_r[DW-1]}}, lb_q_r});
          end
          3'd5: begin
            prod_nxt = acc_r * $signed({1'b0, coef_r});
          end
          3'd6: begin
            g_we  = 1'b1;
            g_wa  = gaddr(ri_r[RIW-1:0], cj_r);
            g_wd  = sat;
            k_nxt = '0;
            if (CCW'(cj_r) == cols_r - CCW'(2)) begin
              // row finished: its old copy becomes the previous row
              bank_nxt = ~bank_r;
              ri_nxt   = ri_dn;
              cj_nxt   = '0;
              if (ri_dn == rows_r - RCW'(1)) begin
                it_nxt = it_r + 16'd1;
                if (it_r + 16'd1 == iter_count_r) begin
                  state_nxt = S_DONE;
                end else begin
                  ri_nxt    = '0;
                  bank_nxt  = 1'b0;
                  state_nxt = S_FILL;
                end
              end else begin
                state_nxt = S_FILL;
              end
            end else begin
              cj_nxt = cj_r + CIW'(1);
            end
          end
          default: k_nxt = '0;
        endcase
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = '0;
          out_kind_nxt  = heat_pkg::KIND_DONE;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  // payload and loop registers, qualified by the state machine
  always_ff @(posedge clk) begin
    ri_r       <= ri_nxt;
    cj_r       <= cj_nxt;
    bank_r     <= bank_nxt;
    it_r       <= it_nxt;
    rows_r     <= rows_nxt;
    cols_r     <= cols_nxt;
    inside_r   <= inside_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    c_r        <= c_nxt;
    out_cell_r <= out_cell_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_cell_out = out_cell_r;
  assign out_kind     = out_kind_r;

endmodule

// File: verif/tb_heat_stencil_solver_unit.sv
`timescale 1ns / 1ps

module tb_heat_stencil_solver_unit;

  // DUT is built with its default grid size
  localparam int GRID_ROWS = heat_pkg::MAX_ROWS_DEF;
  localparam int GRID_COLS = heat_pkg::MAX_COLS_DEF;
  localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
  localparam int DW = heat_pkg::DATA_WIDTH;
  localparam longint CELL_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint CELL_MIN = -CELL_MAX - 1;
  // idle cycles after the last result before touching config (covers a trailing write)
  localparam int SETTLE_CYCLES = 8;
  // idle percentage on both sides, and the one long receiver hold-off
  localparam int IDLE_PCT = 17;
  localparam int STORM_CYCLES = 600;
  // longest legal quiet gap is a 30-sweep run on an 8x8 grid
  localparam int WATCHDOG_LIMIT = 1000000;

  typedef struct {
    logic [heat_pkg::CMD_W-1:0] cmd;
    logic [heat_pkg::IDX_W-1:0] row;
    logic [heat_pkg::IDX_W-1:0] col;
    logic signed [DW-1:0]       temp;
  } heat_req_t;

  typedef struct {
    logic signed [DW-1:0] temp;
    logic                 kind;
  } heat_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [heat_pkg::CMD_W-1:0]       in_command = heat_pkg::CMD_WRITE;
  logic [heat_pkg::IDX_W-1:0]       in_row = '0;
  logic [heat_pkg::IDX_W-1:0]       in_col = '0;
  logic signed [DW-1:0]             in_cell_in = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [DW-1:0]             out_cell_out;
  logic                             out_kind;
  logic                             cfg_we = 1'b0;
  logic [heat_pkg::CFG_IDX_W-1:0]   cfg_index = heat_pkg::REG_ROW_COUNT;
  logic [heat_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  heat_stencil_solver_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_cell_in   (in_cell_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cell_out (out_cell_out),
    .out_kind     (out_kind),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the solver: grid, line buffers and config as the DUT should hold them
  // ---------------------------------------------------------------------------
  longint                      heat_grid [GRID_CELLS];
  longint                      line_above [GRID_COLS];
  longint                      line_here [GRID_COLS];
  logic [heat_pkg::DIM_W-1:0]  rows_cfg = heat_pkg::ROW_COUNT_RST;
  logic [heat_pkg::DIM_W-1:0]  cols_cfg = heat_pkg::COL_COUNT_RST;
  logic [heat_pkg::ITER_W-1:0] sweeps_cfg = heat_pkg::ITER_COUNT_RST;
  logic [heat_pkg::COEF_W-1:0] coef_cfg = heat_pkg::COEF_RST;

  heat_req_t    pending_reqs [$];   // requests waiting for the driver
  heat_result_t due_results [$];    // results the DUT still owes, oldest first

  // stimulus bookkeeping: never read a cell (or sweep over one) that was never written
  bit cell_written [GRID_CELLS];
  int written_idx [$];

  bit steady_flow = 1'b0;   // both sides stop idling while set
  bit stall_storm = 1'b0;   // asks the receiver for its one long hold-off

  int mismatch_count = 0;
  int results_checked = 0;
  int writes_seen = 0;
  int reads_seen = 0;
  int runs_seen = 0;
  int ignored_seen = 0;
  int settings_used = 1;

  task automatic note_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // active rows/cols; registers above the grid size count as the grid size
  function automatic int used_rows();
    return (rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
  endfunction

  function automatic int used_cols();
    return (cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
  endfunction

  function automatic longint clamp_cell(longint x);
    if (x > CELL_MAX) return CELL_MAX;
    if (x < CELL_MIN) return CELL_MIN;
    return x;
  endfunction

  // c + round((u+d+l+r-4c)*k / 2^16), ties toward +inf, then saturate
  function automatic longint stencil_cell(longint c, longint u, longint d, longint l,
                                          longint r);
    longint diff;
    longint prod;
    diff = u + d + l + r - 4 * c;
    prod = diff * longint'(coef_cfg) + 32768;
    return clamp_cell(c + (prod >>> 16));
  endfunction

  // Jacobi-style sweep: up/left/center/right come from the old-row buffers,
  // down is still untouched in the grid. Borders never change.
  function automatic void run_heat_sweeps();
    int rows;
    int cols;
    int s;
    int i;
    int j;
    rows = used_rows();
    cols = used_cols();
    if (rows < 3 || cols < 3) return;
    for (s = 0; s < int'(sweeps_cfg); s++) begin
      for (j = 0; j < cols; j++) line_above[j] = heat_grid[j];
      for (i = 1; i + 1 < rows; i++) begin
        for (j = 0; j < cols; j++) line_here[j] = heat_grid[i * GRID_COLS + j];
        for (j = 1; j + 1 < cols; j++) begin
          heat_grid[i * GRID_COLS + j] =
            stencil_cell(line_here[j], line_above[j], heat_grid[(i + 1) * GRID_COLS + j],
                         line_here[j - 1], line_here[j + 1]);
        end
        for (j = 0; j < cols; j++) line_above[j] = line_here[j];
      end
    end
  endfunction

  // one accepted request -> state update and zero or one expected result
  function automatic void apply_request(heat_req_t req);
    int idx;
    idx = int'(req.row) * GRID_COLS + int'(req.col);
    case (req.cmd)
      heat_pkg::CMD_WRITE: begin
        heat_grid[idx] = longint'(req.temp);
        writes_seen++;
      end
      heat_pkg::CMD_RUN: begin
        run_heat_sweeps();
        due_results.push_back('{temp: '0, kind: heat_pkg::KIND_DONE});
        runs_seen++;
      end
      heat_pkg::CMD_READ: begin
        due_results.push_back('{temp: DW'(heat_grid[idx]), kind: heat_pkg::KIND_READ});
        reads_seen++;
      end
      default: begin
        ignored_seen++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: request channel. Payload holds while stalled; a new request is only
  // loaded once the slot is free, so valid never drops between back-to-back requests.
  // ---------------------------------------------------------------------------
  heat_req_t head_req;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_request('{cmd: in_command, row: in_row, col: in_col, temp: in_cell_in});
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          head_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_command <= head_req.cmd;
          in_row <= head_req.row;
          in_col <= head_req.col;
          in_cell_in <= head_req.temp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result channel. Random stalls, plus one long hold-off so the DUT
  // backs up into its request side.
  // ---------------------------------------------------------------------------
  heat_result_t want;
  int           storm_left = 0;
  bit           storm_taken = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind=%0d cell=%h", out_kind,
                                  out_cell_out));
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind)
            note_mismatch($sformatf("kind got %0d want %0d", out_kind, want.kind));
          if (out_cell_out !== want.temp)
            note_mismatch($sformatf("cell got %h want %h (kind %0d)", out_cell_out,
                                    want.temp, want.kind));
          results_checked++;
        end
      end
      if (storm_left > 0) begin
        storm_left--;
        out_stall <= 1'b1;
      end else if (stall_storm && !storm_taken) begin
        storm_taken = 1'b1;
        storm_left = STORM_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without any request or result moving
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no traffic for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("heat_stencil_solver_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [DW-1:0] random_temp();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4, 5: return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(logic [heat_pkg::CMD_W-1:0] cmd, int row, int col,
                           logic signed [DW-1:0] temp);
    pending_reqs.push_back('{cmd: cmd, row: heat_pkg::IDX_W'(row),
                             col: heat_pkg::IDX_W'(col), temp: temp});
  endtask

  task automatic queue_write(int row, int col, logic signed [DW-1:0] temp);
    int idx;
    idx = row * GRID_COLS + col;
    if (!cell_written[idx]) begin
      cell_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
    queue_req(heat_pkg::CMD_WRITE, row, col, temp);
  endtask

  // sender holds back until nothing is owed, then lets the DUT settle
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // new register setting, written only while idle
  task automatic start_phase(logic [heat_pkg::CFG_DATA_W-1:0] rows_w,
                             logic [heat_pkg::CFG_DATA_W-1:0] cols_w,
                             logic [heat_pkg::CFG_DATA_W-1:0] iters_w,
                             logic [heat_pkg::CFG_DATA_W-1:0] coef_w);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= heat_pkg::REG_ROW_COUNT;
    cfg_wdata <= rows_w;
    @(posedge clk);
    cfg_index <= heat_pkg::REG_COL_COUNT;
    cfg_wdata <= cols_w;
    @(posedge clk);
    cfg_index <= heat_pkg::REG_ITER_COUNT;
    cfg_wdata <= iters_w;
    @(posedge clk);
    cfg_index <= heat_pkg::REG_NEIGHBOR_COEF;
    cfg_wdata <= coef_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_cfg = rows_w[heat_pkg::DIM_W-1:0];
    cols_cfg = cols_w[heat_pkg::DIM_W-1:0];
    sweeps_cfg = iters_w[heat_pkg::ITER_W-1:0];
    coef_cfg = coef_w[heat_pkg::COEF_W-1:0];
    settings_used++;
    @(negedge clk);
  endtask

  // every cell a sweep touches must hold a written value before any run
  task automatic fill_region();
    int rows;
    int cols;
    int i;
    int j;
    rows = used_rows();
    cols = used_cols();
    if (rows < 3 || cols < 3) return;
    for (i = 0; i < rows; i++)
      for (j = 0; j < cols; j++)
        if (!cell_written[i * GRID_COLS + j]) queue_write(i, j, random_temp());
  endtask

  // mostly writes inside the active region and reads of written cells,
  // a few runs and a sprinkle of unused commands
  task automatic mix_requests(int count);
    int rows;
    int cols;
    int pick;
    int idx;
    rows = used_rows();
    cols = used_cols();
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 42) begin
        if (rows > 0 && cols > 0 && $urandom_range(3) != 0)
          queue_write($urandom_range(rows - 1), $urandom_range(cols - 1), random_temp());
        else
          queue_write($urandom_range(GRID_ROWS - 1), $urandom_range(GRID_COLS - 1),
                      random_temp());
      end else if (pick < 84) begin
        idx = written_idx[$urandom_range(written_idx.size() - 1)];
        queue_req(heat_pkg::CMD_READ, idx / GRID_COLS, idx % GRID_COLS, $urandom);
      end else if (pick < 95) begin
        queue_req(heat_pkg::CMD_RUN, $urandom_range(63), $urandom_range(63), $urandom);
      end else begin
        queue_req(heat_pkg::CMD_UNUSED, $urandom_range(63), $urandom_range(63), $urandom);
      end
    end
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting (64x64, one sweep, k = 0.25): corners with extreme values, read back
    queue_write(0, 0, 32'sh7FFF_FFFF);
    queue_write(0, 63, 32'sh8000_0000);
    queue_write(63, 0, -32'sd1);
    queue_write(63, 63, 32'sh0001_0000);
    queue_req(heat_pkg::CMD_READ, 0, 0, '0);
    queue_req(heat_pkg::CMD_READ, 0, 63, '0);
    queue_req(heat_pkg::CMD_UNUSED, 63, 63, 32'sh1234_5678);   // ignored, no result
    queue_req(heat_pkg::CMD_READ, 63, 0, '0);
    queue_req(heat_pkg::CMD_READ, 63, 63, '0);

    // no interior: two rows (upper config bits must be dropped), max sweeps
    start_phase(16'hFF82, 16'd1, 16'hFFFF, 16'hFFFF);
    queue_req(heat_pkg::CMD_RUN, 0, 0, '0);
    // zero rows, oversize cols, zero sweeps, k = 0
    start_phase(16'd0, 16'd127, 16'd0, 16'd0);
    queue_req(heat_pkg::CMD_RUN, 5, 9, '0);

    // 3x3, k at max: hot ring around a cold center drives the center into saturation
    start_phase(16'd3, 16'd3, 16'd1, 16'hFFFF);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        queue_write(i, j, (i == 1 && j == 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    queue_req(heat_pkg::CMD_RUN, 0, 0, '0);
    queue_req(heat_pkg::CMD_READ, 1, 1, '0);

    // k = 0.5 with a neighbor sum of one LSB: product lands exactly on a half
    start_phase(16'd3, 16'd3, 16'd1, 16'd32768);
    queue_write(1, 1, '0);
    queue_write(0, 1, 32'sd1);
    queue_write(2, 1, '0);
    queue_write(1, 0, '0);
    queue_write(1, 2, '0);
    queue_req(heat_pkg::CMD_RUN, 0, 0, '0);
    queue_req(heat_pkg::CMD_READ, 1, 1, '0);

    // wide strip, no idling on either side
    start_phase(16'd3, 16'd64, 16'd2, 16'($urandom_range(65535)));
    steady_flow <= 1'b1;
    fill_region();
    mix_requests(30);

    // tall strip with the long receiver hold-off, then a full drain mid-phase
    start_phase(16'd64, 16'd3, 16'd1, 16'($urandom_range(65535)));
    steady_flow <= 1'b0;
    fill_region();
    mix_requests(40);
    stall_storm <= 1'b1;
    wait_drained();
    mix_requests(20);

    // oversize counts clamp to the grid
    start_phase(16'd127, 16'd3, 16'd3, 16'hFFFF);
    mix_requests(30);
    start_phase(16'd3, 16'd127, 16'd1, 16'd0);
    mix_requests(25);

    // small grids, many sweeps
    start_phase(16'd5, 16'd7, 16'd20, 16'($urandom_range(65535)));
    fill_region();
    mix_requests(30);
    start_phase(16'd4, 16'd4, 16'd150, 16'($urandom_range(65535)));
    mix_requests(20);
    start_phase(16'd1, 16'd64, 16'd5, 16'($urandom_range(65535)));
    mix_requests(20);

    repeat (3) begin
      start_phase(16'($urandom_range(3, 8)), 16'($urandom_range(3, 8)),
                  16'($urandom_range(1, 30)), 16'($urandom_range(65535)));
      fill_region();
      mix_requests(20);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    n = due_results.size();
    if (n != 0) note_mismatch($sformatf("%0d results never arrived", n));

    $display("covered %0d cell writes, %0d reads, %0d sweep runs, %0d unused commands",
             writes_seen, reads_seen, runs_seen, ignored_seen);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             settings_used, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("heat_stencil_solver_unit regression: pass");
    end else begin
      $display("heat_stencil_solver_unit regression: fail");
    end
    $finish;
  end

endmodule
